### rtl/rokt_pkg.sv
// ----------------------------------------------------------------------------
// rokt_pkg: shared types and constants
// Codes, field widths, state type and the cell control bundle of the
// recency-ordered key table.
// ----------------------------------------------------------------------------
package rokt_pkg;

    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned KEY_W     = 24;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned FIELD_W   = 5;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned PADDR_W   = 3;

    localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd60;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_FIND   = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_TOUCH  = 3'd3,
        FUNC_AGE    = 3'd4,
        FUNC_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_MATCH = 3'd1,
        S_EXEC  = 3'd2,
        S_AGE   = 3'd3,
        S_DONE  = 3'd4
    } t_state;

    // Broadcast command to every cell of the chain.
    typedef struct packed {
        logic shift_req; // cells in the gap window take their right neighbor
        logic load_req;  // the cell at the tail index takes the new entry
    } t_cell_ctl;

endpackage

### rtl/rokt_cell.sv
// ----------------------------------------------------------------------------
// rokt_cell: one slot of the key table
// Holds one key and its stamp, compares the key against the probe and
// shifts in its right neighbor or loads a new entry on command.
// ----------------------------------------------------------------------------
module rokt_cell
    import rokt_pkg::*;
#(
    parameter int unsigned CW       = 5,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_gap,
    input  logic [CW-1:0]     i_tail,
    input  logic [CW-1:0]     i_count,
    input  logic [KEY_W-1:0]  i_probe_key,
    input  logic [KEY_W-1:0]  i_new_key,
    input  logic [TIME_W-1:0] i_new_stamp,
    input  logic [KEY_W-1:0]  i_nb_key,
    input  logic [TIME_W-1:0] i_nb_stamp,
    output logic [KEY_W-1:0]  o_key,
    output logic [TIME_W-1:0] o_stamp,
    output logic              o_hit
);

    localparam logic [CW-1:0] L_IDX  = CW'(CELL_IDX);
    localparam logic [CW-1:0] L_NEXT = CW'(CELL_IDX + 1);

    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_stamp;
    logic              w_shift;
    logic              w_load;

    // Load wins over shift: touch shifts the window below the tail only.
    assign w_shift = i_ctl.shift_req && (L_IDX >= i_gap) && (L_NEXT < i_count);
    assign w_load  = i_ctl.load_req && (L_IDX == i_tail);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key   <= i_new_key;
            r_stamp <= i_new_stamp;
        end else if (w_shift) begin
            r_key   <= i_nb_key;
            r_stamp <= i_nb_stamp;
        end
    end

    assign o_key   = r_key;
    assign o_stamp = r_stamp;
    assign o_hit   = (r_key == i_probe_key) && (L_IDX < i_count);

endmodule

### rtl/recency_ordered_key_table_with_aging.sv
// ----------------------------------------------------------------------------
// recency_ordered_key_table_with_aging: LRU key table with timeout drop
// Keeps up to TABLE_DEPTH 24-bit addresses oldest first in a row of cells,
// each with a time stamp; serves insert, find, remove, touch, age, clear.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  request  | in        | i_in_valid / o_in_stall | i_func, i_icao, i_now
//  result   | out       | o_out_valid / i_out_stall| o_status, o_position,
//           |           |                        | o_entry_total, o_dropped
//  config   | in        | APB (psel, penable)    | age_limit at byte address 0
//
//  Steps: a request is taken in idle, its hits are registered in the match
//  state, the table is updated in the exec state, and the result register
//  loads in the done state. Age adds an age state that checks the head
//  and pops expired entries until the head is not expired, since the chain
//  pops one head entry per cycle.
//  Reset: clears the entry count and sets age_limit to 60; the cells are
//  not cleared, since slots at or beyond the count are never read.
//  Stalls: a finished result waits in the result register while the next
//  request is taken; a request holds in its final step while the result
//  register is full and stalled.
//
module recency_ordered_key_table_with_aging
    import rokt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [KEY_W-1:0]   i_icao,
    input  logic [TIME_W-1:0]  i_now,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [FIELD_W-1:0] o_position,
    output logic [FIELD_W-1:0] o_entry_total,
    output logic [FIELD_W-1:0] o_dropped,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    // Count width holds TABLE_DEPTH itself.
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] L_DEPTH = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] L_ONE   = CW'(1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    t_func               r_func;
    logic [KEY_W-1:0]    r_key;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_limit;
    logic [CW-1:0]       r_count, n_count;
    logic [TABLE_DEPTH-1:0] r_hit;
    t_status             r_status, n_status;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_drop, n_drop;

    logic                r_out_valid, n_out_valid;
    t_status             r_o_status;
    logic [FIELD_W-1:0]  r_o_pos;
    logic [FIELD_W-1:0]  r_o_total;
    logic [FIELD_W-1:0]  r_o_drop;

    // ------------------------------------------------------------------
    // Chain wiring
    // ------------------------------------------------------------------
    t_cell_ctl           w_ctl;
    logic [CW-1:0]       w_gap;
    logic [CW-1:0]       w_tail;
    logic [KEY_W-1:0]    w_key   [TABLE_DEPTH];
    logic [TIME_W-1:0]   w_stamp [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit;

    logic                w_in_take;
    logic                w_out_free;
    logic                w_cfg_wr;
    logic                w_found;
    logic [CW-1:0]       w_idx;
    logic [TIME_W-1:0]   w_age;
    logic                w_expired;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic [KEY_W-1:0]  w_nb_key;
            logic [TIME_W-1:0] w_nb_stamp;

            // The last cell never shifts; feed it zeros.
            if (gi < TABLE_DEPTH - 1) begin : g_nb
                assign w_nb_key   = w_key[gi+1];
                assign w_nb_stamp = w_stamp[gi+1];
            end else begin : g_end
                assign w_nb_key   = '0;
                assign w_nb_stamp = '0;
            end

            rokt_cell #(
                .CW       (CW),
                .CELL_IDX (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_gap       (w_gap),
                .i_tail      (w_tail),
                .i_count     (r_count),
                .i_probe_key (r_key),
                .i_new_key   (r_key),
                .i_new_stamp (r_now),
                .i_nb_key    (w_nb_key),
                .i_nb_stamp  (w_nb_stamp),
                .o_key       (w_key[gi]),
                .o_stamp     (w_stamp[gi]),
                .o_hit       (w_hit[gi])
            );
        end
    endgenerate

    // Keys are unique among valid slots, so at most one hit is set and
    // an OR of the hit positions gives its index.
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_hit[i]) begin
                w_idx = w_idx | CW'(i);
            end
        end
    end
    assign w_found = |r_hit;

    // Age of the head entry, wrapping 32-bit.
    assign w_age     = r_now - w_stamp[0];
    assign w_expired = (r_count != '0) && (w_age > r_limit);

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_func == FUNC_AGE) begin
                    n_state = S_AGE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_AGE: begin
                if (!w_expired) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall        = (r_state != S_IDLE);
        w_ctl.shift_req   = 1'b0;
        w_ctl.load_req    = 1'b0;
        w_gap             = '0;
        w_tail            = r_count;
        n_count           = r_count;
        n_status          = r_status;
        n_pos             = r_pos;
        n_drop            = r_drop;
        n_out_valid       = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                n_status = ST_OK;
                n_pos    = '0;
                n_drop   = '0;
            end
            S_MATCH: begin
                // hits are registered this cycle
            end
            S_EXEC: begin
                unique case (r_func)
                    FUNC_INSERT: begin
                        if (w_found) begin
                            n_status = ST_PRESENT;
                            n_pos    = w_idx;
                        end else if (r_count >= L_DEPTH) begin
                            n_status = ST_FULL;
                        end else begin
                            // append at the tail
                            w_ctl.load_req = 1'b1;
                            w_tail         = r_count;
                            n_pos          = r_count;
                            n_count        = r_count + L_ONE;
                        end
                    end
                    FUNC_FIND: begin
                        if (w_found) begin
                            n_pos = w_idx;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (w_found) begin
                            // close the gap behind the entry
                            w_ctl.shift_req = 1'b1;
                            w_gap           = w_idx;
                            n_pos           = w_idx;
                            n_drop          = L_ONE;
                            n_count         = r_count - L_ONE;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FUNC_TOUCH: begin
                        if (w_found) begin
                            // close the gap and reload the key at the tail
                            w_ctl.shift_req = 1'b1;
                            w_ctl.load_req  = 1'b1;
                            w_gap           = w_idx;
                            w_tail          = r_count - L_ONE;
                            n_pos           = r_count - L_ONE;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    FUNC_AGE: begin
                        n_drop = '0;
                    end
                    FUNC_CLEAR: begin
                        n_drop  = r_count;
                        n_count = '0;
                    end
                    default: begin
                        // unused codes leave the table alone
                    end
                endcase
            end
            S_AGE: begin
                // pop one expired head entry per cycle
                if (w_expired) begin
                    w_ctl.shift_req = 1'b1;
                    w_gap           = '0;
                    n_count         = r_count - L_ONE;
                    n_drop          = r_drop + L_ONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
    assign prdata   = (paddr[PADDR_W-1] == 1'b0) ? r_limit : '0;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= AGE_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_limit <= pwdata;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_func <= t_func'(i_func);
            r_key  <= i_icao;
            r_now  <= i_now;
        end
        r_hit    <= w_hit;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_drop   <= n_drop;
        // load the result register on the final step of a request
        if (r_state == S_DONE && w_out_free) begin
            r_o_status <= r_status;
            r_o_pos    <= FIELD_W'(r_pos);
            r_o_total  <= FIELD_W'(r_count);
            r_o_drop   <= FIELD_W'(r_drop);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_entry_total = r_o_total;
    assign o_dropped     = r_o_drop;

endmodule
